>>> src/dfa_tt_pkg.sv
// ----------------------------------------------------------------------------
// dfa_tt_pkg
// shared constants, codes and types of the automaton transition table
// ----------------------------------------------------------------------------
package dfa_tt_pkg;

  // entry store geometry
  localparam int unsigned MaxEntries = 256;
  localparam int unsigned EntryIdxW  = $clog2(MaxEntries);
  localparam int unsigned CountW     = EntryIdxW + 1;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned StateW  = 7;
  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned KeyW    = StateW + CharW;
  localparam int unsigned EntryW  = KeyW + StateW;

  // states in use may not exceed this
  localparam int unsigned MaxStates = 128;

  // accepting map covers every state code
  localparam int unsigned MapAddrW = StateW;
  localparam int unsigned MapDepth = 1 << MapAddrW;

  typedef enum logic [OpW-1:0] {
    OpAdd       = 2'd0,
    OpSetAccept = 2'd1,
    OpLookup    = 2'd2,
    OpNone      = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatOk        = 3'd0,
    StatIgnored   = 3'd1,
    StatDuplicate = 3'd2,
    StatFull      = 3'd3,
    StatBadState  = 3'd4
  } status_e;

  // request to the accepting map
  typedef struct packed {
    logic                we;
    logic [MapAddrW-1:0] waddr;
    logic                wdata;
    logic                re;
    logic [MapAddrW-1:0] raddr;
  } acc_req_t;

endpackage

>>> src/dfa_tt_in_if.sv
// ----------------------------------------------------------------------------
// dfa_tt_in_if
// request channel: valid/ready handshake with one command per transaction
// ----------------------------------------------------------------------------
interface dfa_tt_in_if;

  logic                           valid;
  logic                           ready;
  logic [dfa_tt_pkg::OpW-1:0]     opcode;
  logic [dfa_tt_pkg::StateW-1:0]  state_id;
  logic [dfa_tt_pkg::CharW-1:0]   char_code;
  logic [dfa_tt_pkg::StateW-1:0]  target_state;
  logic                           accept_flag;

  modport source (
    output valid, opcode, state_id, char_code, target_state, accept_flag,
    input  ready
  );

  modport sink (
    input  valid, opcode, state_id, char_code, target_state, accept_flag,
    output ready
  );

endinterface

>>> src/dfa_tt_out_if.sv
// ----------------------------------------------------------------------------
// dfa_tt_out_if
// response channel: valid/ready handshake with one result per transaction
// ----------------------------------------------------------------------------
interface dfa_tt_out_if;

  logic                            valid;
  logic                            ready;
  logic [dfa_tt_pkg::StateW-1:0]   nxt_state;
  logic                            is_accepting;
  logic [dfa_tt_pkg::StatusW-1:0]  status;

  modport source (
    output valid, nxt_state, is_accepting, status,
    input  ready
  );

  modport sink (
    input  valid, nxt_state, is_accepting, status,
    output ready
  );

endinterface

>>> src/dfa_tt_ram.sv
// ----------------------------------------------------------------------------
// dfa_tt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dfa_tt_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/dfa_tt_accept.sv
// ----------------------------------------------------------------------------
// dfa_tt_accept
// accepting-state map: ram plus per-state valid bits that reset clears
// ----------------------------------------------------------------------------
module dfa_tt_accept (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dfa_tt_pkg::acc_req_t req_i,
  output logic                 rd_flag_o
);

  import dfa_tt_pkg::*;

  logic [MapDepth-1:0] valid_q;
  logic                rd_valid_q;
  logic                ram_rdata;

  dfa_tt_ram #(
    .Width (1),
    .Depth (MapDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // a never-written state reads as not accepting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_flag_o = rd_valid_q & ram_rdata;

endmodule

>>> src/dfa_transition_table.sv
// ----------------------------------------------------------------------------
// dfa_transition_table
// sparse transition table of a scanner automaton, state 0 is the error state
// ----------------------------------------------------------------------------
// One command is handled at a time and each gives exactly one response.
// Add and lookup scan the entry store from slot 0 in insertion order, one
// entry per cycle through the single read port of the entry ram, in the
// steps accept, decode, scan, write-back or accepting-map read, response;
// a lookup that hits slot k ends its scan there. A set command goes from
// decode straight to the response, as do commands rejected by the range or
// error-state checks. A new command is accepted while the previous
// response still sits in the output register. The entry store is tracked by
// a fill count and the accepting map by per-state valid bits, so no clearing
// pass follows reset. state_count is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module dfa_transition_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dfa_tt_in_if.sink                   in_i,
  dfa_tt_out_if.source                out_o,
  input  logic                        cfg_we_i,
  input  logic [dfa_tt_pkg::CfgW-1:0] cfg_wdata_i
);

  import dfa_tt_pkg::*;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmDecode,
    FsmScan,
    FsmWrite,
    FsmAcc,
    FsmResp
  } fsm_e;

  // control and command registers
  fsm_e              fsm_q, fsm_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [StateW-1:0] st_q, st_d;
  logic [CharW-1:0]  ch_q, ch_d;
  logic [StateW-1:0] tgt_q, tgt_d;
  logic              flag_q, flag_d;
  logic [CfgW-1:0]   state_count_q, state_count_d;
  logic [CountW-1:0] count_q, count_d;

  // scan pipeline: issue pointer and read-in-flight flag
  logic [CountW-1:0] issue_q, issue_d;
  logic              pend_q, pend_d;

  // pending result
  logic [StateW-1:0] res_next_q, res_next_d;
  logic              res_acc_q, res_acc_d;
  status_e           res_status_q, res_status_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [StateW-1:0]  out_next_q, out_next_d;
  logic               out_acc_q, out_acc_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  // memory ports
  logic                 ent_we;
  logic [EntryIdxW-1:0] ent_waddr;
  logic [EntryW-1:0]    ent_wdata;
  logic                 ent_re;
  logic [EntryW-1:0]    ent_rdata;
  acc_req_t             acc_req;
  logic                 acc_rd_flag;

  // decode helpers
  logic [CfgW-1:0]   n_eff;
  logic              st_ok;
  logic              tgt_ok;
  logic              more;
  logic              key_match;
  logic              scan_done;
  logic              res_load;
  logic [StateW-1:0] lookup_next;

  dfa_tt_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (issue_q[EntryIdxW-1:0]),
    .rdata_o (ent_rdata)
  );

  dfa_tt_accept u_accept (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (acc_req),
    .rd_flag_o (acc_rd_flag)
  );

  // state count of zero acts as one, above the maximum it saturates
  always_comb begin
    if (state_count_q == '0) begin
      n_eff = CfgW'(1);
    end else if (state_count_q > CfgW'(MaxStates)) begin
      n_eff = CfgW'(MaxStates);
    end else begin
      n_eff = state_count_q;
    end
  end

  assign st_ok  = CfgW'(st_q) < n_eff;
  assign tgt_ok = CfgW'(tgt_q) < n_eff;

  // entry read issued last cycle is compared this cycle
  assign more        = issue_q < count_q;
  assign key_match   = pend_q && (ent_rdata[EntryW-1:StateW] == {st_q, ch_q});
  assign scan_done   = key_match || (!pend_q && !more);
  assign lookup_next = key_match ? ent_rdata[StateW-1:0] : '0;

  // result moves into the output register when it is free or being emptied
  assign res_load = (fsm_q == FsmResp) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (fsm_q == FsmIdle);

  always_comb begin
    fsm_d         = fsm_q;
    op_d          = op_q;
    st_d          = st_q;
    ch_d          = ch_q;
    tgt_d         = tgt_q;
    flag_d        = flag_q;
    state_count_d = state_count_q;
    count_d       = count_q;
    issue_d       = issue_q;
    pend_d        = pend_q;
    res_next_d    = res_next_q;
    res_acc_d     = res_acc_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q;
    out_next_d    = out_next_q;
    out_acc_d     = out_acc_q;
    out_status_d  = out_status_q;

    ent_we    = 1'b0;
    ent_waddr = count_q[EntryIdxW-1:0];
    ent_wdata = {st_q, ch_q, tgt_q};
    ent_re    = 1'b0;
    acc_req   = '0;

    if (cfg_we_i) begin
      state_count_d = cfg_wdata_i;
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (fsm_q)
      FsmIdle: begin
        if (in_i.valid) begin
          op_d   = in_i.opcode;
          st_d   = in_i.state_id;
          ch_d   = in_i.char_code;
          tgt_d  = in_i.target_state;
          flag_d = in_i.accept_flag;
          fsm_d  = FsmDecode;
        end
      end

      FsmDecode: begin
        res_next_d   = '0;
        res_acc_d    = 1'b0;
        res_status_d = StatOk;
        issue_d      = '0;
        pend_d       = 1'b0;
        fsm_d        = FsmResp;
        case (op_q)
          OpAdd: begin
            // error-state check takes priority over the range check
            if (st_q == '0 || tgt_q == '0) begin
              res_status_d = StatIgnored;
            end else if (!st_ok || !tgt_ok) begin
              res_status_d = StatBadState;
            end else if (count_q == CountW'(MaxEntries)) begin
              res_status_d = StatFull;
            end else begin
              fsm_d = FsmScan;
            end
          end
          OpSetAccept: begin
            if (!st_ok) begin
              res_status_d = StatBadState;
            end else begin
              acc_req.we    = 1'b1;
              acc_req.waddr = st_q;
              acc_req.wdata = flag_q;
            end
          end
          OpLookup: begin
            if (!st_ok) begin
              res_status_d = StatBadState;
            end else begin
              fsm_d = FsmScan;
            end
          end
          default: begin
            // unused opcode answers with all zeros
          end
        endcase
      end

      FsmScan: begin
        ent_re = more;
        pend_d = more;
        if (more) begin
          issue_d = issue_q + 1'b1;
        end
        if (scan_done) begin
          pend_d = 1'b0;
          if (op_q == OpAdd) begin
            res_status_d = key_match ? StatDuplicate : StatOk;
            fsm_d        = FsmWrite;
          end else begin
            // first match wins, then fetch the mark of the next state
            res_next_d    = lookup_next;
            acc_req.re    = 1'b1;
            acc_req.raddr = lookup_next;
            fsm_d         = FsmAcc;
          end
        end
      end

      FsmWrite: begin
        // append in the next free slot
        ent_we  = 1'b1;
        count_d = count_q + 1'b1;
        fsm_d   = FsmResp;
      end

      FsmAcc: begin
        res_acc_d = acc_rd_flag;
        fsm_d     = FsmResp;
      end

      FsmResp: begin
        if (res_load) begin
          out_valid_d  = 1'b1;
          out_next_d   = res_next_q;
          out_acc_d    = res_acc_q;
          out_status_d = res_status_q;
          fsm_d        = FsmIdle;
        end
      end

      default: begin
        fsm_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= FsmIdle;
      op_q          <= '0;
      st_q          <= '0;
      ch_q          <= '0;
      tgt_q         <= '0;
      flag_q        <= 1'b0;
      state_count_q <= CfgW'(1);
      count_q       <= '0;
      issue_q       <= '0;
      pend_q        <= 1'b0;
      res_next_q    <= '0;
      res_acc_q     <= 1'b0;
      res_status_q  <= StatOk;
      out_valid_q   <= 1'b0;
      out_next_q    <= '0;
      out_acc_q     <= 1'b0;
      out_status_q  <= '0;
    end else begin
      fsm_q         <= fsm_d;
      op_q          <= op_d;
      st_q          <= st_d;
      ch_q          <= ch_d;
      tgt_q         <= tgt_d;
      flag_q        <= flag_d;
      state_count_q <= state_count_d;
      count_q       <= count_d;
      issue_q       <= issue_d;
      pend_q        <= pend_d;
      res_next_q    <= res_next_d;
      res_acc_q     <= res_acc_d;
      res_status_q  <= res_status_d;
      out_valid_q   <= out_valid_d;
      out_next_q    <= out_next_d;
      out_acc_q     <= out_acc_d;
      out_status_q  <= out_status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.nxt_state    = out_next_q;
  assign out_o.is_accepting = out_acc_q;
  assign out_o.status       = out_status_q;

`ifndef ASSERT_OFF
  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxEntries))
    else $error("entry count above store depth");

  // an entry is only appended while a slot is free
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (count_q < CountW'(MaxEntries)))
    else $error("entry write into a full store");

  // every append bumps the fill count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |=> (count_q == $past(count_q) + CountW'(1)))
    else $error("fill count out of step with entry writes");

  // a response never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_o.ready))
    else $error("response overwritten before transaction");
`endif

endmodule

>>> tb/sv/dfa_transition_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfa_transition_table_tb
// self-checking regression of the automaton transition table
// ----------------------------------------------------------------------------
// Commands go in as transactions with random gaps while a shadow copy of the
// entry store, fill count, accepting map and state_count predicts every
// response. Responses are checked field by field, in order, as they leave
// the block. Directed tests cover the error-state rules, extreme entries,
// count clamping and stale targets. Random phases then sweep state_count,
// back-pressure is applied, and the table is filled up to overflow.
// ----------------------------------------------------------------------------
module dfa_transition_table_tb;
  import dfa_tt_pkg::*;

  typedef struct {
    logic [StateW-1:0] nxt_state;
    logic              is_accepting;
    status_e           status;
  } response_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  dfa_tt_in_if  cmd_if ();
  dfa_tt_out_if rsp_if ();

  dfa_transition_table i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (cmd_if),
    .out_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block state, entries kept in insertion order
  logic [StateW-1:0] shadow_src  [MaxEntries];
  logic [CharW-1:0]  shadow_char [MaxEntries];
  logic [StateW-1:0] shadow_dst  [MaxEntries];
  int unsigned       shadow_fill = 0;
  logic              shadow_accept [MapDepth];
  logic [CfgW-1:0]   shadow_state_count = 8'd1;

  // responses predicted for accepted commands, oldest first
  response_t   pending_responses [$];
  int unsigned mismatch_count = 0;

  // idle control of both sides
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_gap = 0;
  int unsigned rx_hold_cycles = 0;

  // state_count as the block applies it: 0 acts as 1, large values clamp
  function automatic int unsigned live_states();
    if (shadow_state_count == 0) return 1;
    if (shadow_state_count > MaxStates) return MaxStates;
    return shadow_state_count;
  endfunction

  // applies one command to the shadow state and returns its response
  function automatic response_t predict_response(opcode_e op, logic [StateW-1:0] st,
                                                 logic [CharW-1:0] ch,
                                                 logic [StateW-1:0] tgt, logic flag);
    response_t   r;
    int unsigned lim;
    int          first;
    r.nxt_state    = '0;
    r.is_accepting = 1'b0;
    r.status       = StatOk;
    lim   = live_states();
    first = -1;
    // first-added entry wins for a (state, char) pair
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (first < 0 && shadow_src[i] == st && shadow_char[i] == ch) first = i;
    end
    case (op)
      OpAdd: begin
        // zero-state check comes before the range check
        if (st == 0 || tgt == 0) r.status = StatIgnored;
        else if (st >= lim || tgt >= lim) r.status = StatBadState;
        else if (shadow_fill >= MaxEntries) r.status = StatFull;
        else begin
          // a duplicate is still stored, it just never wins a lookup
          if (first >= 0) r.status = StatDuplicate;
          shadow_src[shadow_fill]  = st;
          shadow_char[shadow_fill] = ch;
          shadow_dst[shadow_fill]  = tgt;
          shadow_fill++;
        end
      end
      OpSetAccept: begin
        if (st >= lim) r.status = StatBadState;
        else shadow_accept[st] = flag;
      end
      OpLookup: begin
        if (st >= lim) r.status = StatBadState;
        else begin
          // a miss gives state 0, whose mark is reported as is
          if (first >= 0) r.nxt_state = shadow_dst[first];
          r.is_accepting = shadow_accept[r.nxt_state];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // drives one command transaction, valid stays high into the next call
  task automatic send_command(opcode_e op, logic [StateW-1:0] st, logic [CharW-1:0] ch,
                              logic [StateW-1:0] tgt, logic flag);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid        = 1'b1;
    cmd_if.opcode       = op;
    cmd_if.state_id     = st;
    cmd_if.char_code    = ch;
    cmd_if.target_state = tgt;
    cmd_if.accept_flag  = flag;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pending_responses.push_back(predict_response(op, st, ch, tgt, flag));
    @(negedge clk);
  endtask

  // stops sending and waits for every predicted response
  task automatic wait_drained();
    cmd_if.valid = 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_state_count(logic [CfgW-1:0] value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_state_count = value;
  endtask

  // mostly well-formed commands over a small alphabet, some noise
  task automatic send_random_command();
    int unsigned       lim;
    int unsigned       roll;
    int unsigned       k;
    opcode_e           op;
    logic [StateW-1:0] st;
    logic [StateW-1:0] tgt;
    logic [CharW-1:0]  ch;
    logic              flag;
    lim  = live_states();
    roll = $urandom_range(0, 99);
    st   = 7'($urandom_range(0, lim - 1));
    tgt  = 7'($urandom_range(0, lim - 1));
    ch   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h64));
    flag = 1'($urandom);
    if (roll < 30) op = OpAdd;
    else if (roll < 45) op = OpSetAccept;
    else if (roll < 90) begin
      op = OpLookup;
      // usually look up a pair that was stored
      if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
        k  = $urandom_range(0, shadow_fill - 1);
        st = shadow_src[k];
        ch = shadow_char[k];
      end
    end else begin
      op  = opcode_e'($urandom_range(0, 3));
      st  = 7'($urandom);
      tgt = 7'($urandom);
    end
    send_command(op, st, ch, tgt, flag);
  endtask

  // reset count of 1: only the error state exists
  task automatic test_error_state_rules();
    send_command(OpLookup,    7'd0,   8'h00, 7'd0,   1'b0);
    send_command(OpSetAccept, 7'd0,   8'h00, 7'd0,   1'b1);
    send_command(OpLookup,    7'd0,   8'hff, 7'd0,   1'b0);
    send_command(OpAdd,       7'd0,   8'h61, 7'd5,   1'b1);
    send_command(OpAdd,       7'd1,   8'h61, 7'd0,   1'b0);
    send_command(OpAdd,       7'd1,   8'h61, 7'd1,   1'b0);
    send_command(OpSetAccept, 7'd127, 8'h00, 7'd0,   1'b1);
    send_command(OpLookup,    7'd1,   8'h61, 7'd0,   1'b0);
    send_command(OpNone,      7'd127, 8'hff, 7'd127, 1'b1);
  endtask

  // extreme states and chars, duplicate pair, hit and miss lookups
  task automatic test_table_extremes();
    write_state_count(8'd128);
    send_command(OpAdd,       7'd127, 8'hff, 7'd127, 1'b0);
    send_command(OpAdd,       7'd1,   8'h00, 7'd127, 1'b0);
    send_command(OpAdd,       7'd1,   8'h00, 7'd2,   1'b1);
    send_command(OpLookup,    7'd1,   8'h00, 7'd0,   1'b0);
    send_command(OpSetAccept, 7'd127, 8'h00, 7'd0,   1'b1);
    send_command(OpLookup,    7'd1,   8'h00, 7'd0,   1'b0);
    send_command(OpLookup,    7'd127, 8'hff, 7'd0,   1'b0);
    send_command(OpLookup,    7'd127, 8'hfe, 7'd0,   1'b0);
    send_command(OpSetAccept, 7'd0,   8'h00, 7'd0,   1'b0);
  endtask

  // zero acts as one, values above the maximum clamp
  task automatic test_count_clamping();
    write_state_count(8'd0);
    send_command(OpLookup, 7'd1,   8'h00, 7'd0, 1'b0);
    send_command(OpAdd,    7'd1,   8'h41, 7'd1, 1'b0);
    write_state_count(8'd255);
    send_command(OpLookup, 7'd127, 8'hff, 7'd0, 1'b0);
  endtask

  // lowering the count leaves targets above it reachable
  task automatic test_stale_target();
    write_state_count(8'd128);
    send_command(OpAdd,       7'd3,   8'h78, 7'd100, 1'b0);
    send_command(OpSetAccept, 7'd100, 8'h00, 7'd0,   1'b1);
    write_state_count(8'd4);
    send_command(OpLookup,    7'd3,   8'h78, 7'd0,   1'b0);
    send_command(OpLookup,    7'd100, 8'h78, 7'd0,   1'b0);
  endtask

  // sweep of counts, idling on and off per phase
  task automatic test_random_phases();
    logic [CfgW-1:0] counts [10] = '{8'd2, 8'd128, 8'd5, 8'd255, 8'd0,
                                     8'd17, 8'd1, 8'd64, 8'd3, 8'd100};
    for (int p = 0; p < 10; p++) begin
      write_state_count(counts[p]);
      tx_idle_en = (p % 3) != 2;
      rx_idle_en = (p % 4) != 3;
      repeat (190) send_random_command();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // long receiver hold-off fills the block, then the sender drains
  task automatic test_backpressure();
    write_state_count(8'd6);
    rx_hold_cycles = 300;
    repeat (12) send_random_command();
    wait_drained();
    repeat (20) send_random_command();
  endtask

  // tops the store up to its last slot, then overflows it
  task automatic test_table_full();
    write_state_count(8'(MaxStates));
    while (shadow_fill < MaxEntries) begin
      send_command(OpAdd, 7'($urandom_range(1, 127)), 8'($urandom),
                   7'($urandom_range(1, 127)), 1'b0);
    end
    repeat (40) send_random_command();
  endtask

  // response ready, with per-transaction gaps and the long hold-off
  initial begin : response_ready
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rsp_if.ready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_gap > 0) begin
        rsp_if.ready = 1'b0;
        rx_gap--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // compares each response transaction with the oldest prediction
  always @(posedge clk) begin : response_check
    response_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response next=%0d acc=%0d status=%0d",
                                  rsp_if.nxt_state, rsp_if.is_accepting, rsp_if.status));
      end else begin
        want = pending_responses.pop_front();
        if (rsp_if.nxt_state !== want.nxt_state)
          report_mismatch($sformatf("nxt_state %0d, predicted %0d",
                                    rsp_if.nxt_state, want.nxt_state));
        if (rsp_if.is_accepting !== want.is_accepting)
          report_mismatch($sformatf("is_accepting %0d, predicted %0d",
                                    rsp_if.is_accepting, want.is_accepting));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    rsp_if.status, want.status));
      end
      rx_gap = rx_idle_en ? $urandom_range(0, 5) : 0;
    end
  end

  initial begin : stimulus
    cmd_if.valid        = 1'b0;
    cmd_if.opcode       = OpAdd;
    cmd_if.state_id     = '0;
    cmd_if.char_code    = '0;
    cmd_if.target_state = '0;
    cmd_if.accept_flag  = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    foreach (shadow_accept[i]) shadow_accept[i] = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_error_state_rules();
    test_table_extremes();
    test_count_clamping();
    test_stale_target();
    test_random_phases();
    test_backpressure();
    test_table_full();

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #30_000_000;
    $display("timeout with %0d responses outstanding", pending_responses.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
